/* rtl/ppmfd_pkg.sv */
package ppmfd_pkg;

  // Largest channel count the 3-bit channel fields can address
  localparam int unsigned MaxChannels = 8;

  // Configuration register indexes
  localparam logic [0:0] REG_TIMER_PERIOD = 1'b0;
  localparam logic [0:0] REG_SYNC_GAP     = 1'b1;

  // Configuration reset values
  localparam logic [15:0] TIMER_PERIOD_RST = 16'd60000;
  localparam logic [15:0] SYNC_GAP_RST     = 16'd2100;

  // Item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Result codes
  typedef enum logic [2:0] {
    EV_ARMED     = 3'd0,
    EV_SYNC      = 3'd1,
    EV_STORED    = 3'd2,
    EV_DROPPED   = 3'd3,
    EV_READ_HIT  = 3'd4,
    EV_READ_MISS = 3'd5
  } ppmfd_event_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] edge_time;
    logic [62:0] stamp_time;
    logic [2:0]  channel_index;
  } ppmfd_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  channel;
    logic [15:0] pulse_width;
    logic [15:0] min_width;
    logic [15:0] max_width;
    logic [62:0] update_stamp;
    logic [3:0]  channel_count;
  } ppmfd_result_t;

  // One channel record as kept in the channel memory
  typedef struct packed {
    logic [15:0] width;
    logic [15:0] min_w;
    logic [15:0] max_w;
    logic [62:0] stamp;
  } ppmfd_rec_t;

  localparam ppmfd_rec_t REC_RST = '{width: 16'h0000, min_w: 16'hFFFF,
                                     max_w: 16'h0000, stamp: 63'd0};

  // Decoded operation handed from the edge front end to the update stage
  typedef struct packed {
    ppmfd_event_t ev;
    logic [2:0]   chan;
    logic [15:0]  width;
    logic [62:0]  stamp;
    logic [3:0]   count;
  } ppmfd_op_t;

endpackage

/* rtl/ppmfd_chan_mem.sv */
module ppmfd_chan_mem import ppmfd_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rd_en,
  input  logic [2:0] rd_chan,
  input  logic       wr_en,
  input  logic [2:0] wr_chan,
  input  ppmfd_rec_t wr_rec,
  output ppmfd_rec_t rd_rec
);

  localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  ppmfd_rec_t              mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] written;
  logic [AW-1:0]           rd_idx;
  logic [AW-1:0]           wr_idx;
  ppmfd_rec_t              mem_q;
  logic                    vld_q;
  logic                    fwd_q;
  ppmfd_rec_t              fwd_rec;

  // Out-of-range reads (misses) go to entry 0; their data is never used
  assign rd_idx = ({1'b0, rd_chan} < 4'(NUM_CHANNELS)) ? rd_chan[AW-1:0] : '0;
  assign wr_idx = wr_chan[AW-1:0];

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_rec;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_idx];
      fwd_rec <= wr_rec;
    end
  end

  // Per-entry written flags and read-side bypass of a same-edge write
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      vld_q   <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= written[rd_idx];
        fwd_q <= wr_en && (wr_idx == rd_idx);
      end
    end
  end

  // Never-written entries read as their reset record
  always_comb begin
    if (fwd_q) begin
      rd_rec = fwd_rec;
    end else if (vld_q) begin
      rd_rec = mem_q;
    end else begin
      rd_rec = REC_RST;
    end
  end

endmodule

/* rtl/ppmfd_edge_ctrl.sv */
module ppmfd_edge_ctrl import ppmfd_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  ppmfd_item_t item,
  input  logic [15:0] timer_period,
  input  logic [15:0] sync_gap,
  output ppmfd_op_t   op
);

  logic        armed, armed_next;
  logic [15:0] last_edge, last_edge_next;
  logic [3:0]  next_channel, next_channel_next;
  logic [3:0]  latched_count, latched_count_next;

  logic [16:0] period;
  logic [17:0] wrap_sum;
  logic [16:0] gap;
  logic        is_sync;
  logic [15:0] gap_sat;
  logic        read_hit;

  // Gap since the previous edge, modulo the timer period
  always_comb begin
    period   = (timer_period == 16'd0) ? 17'h10000 : {1'b0, timer_period};
    wrap_sum = 18'(item.edge_time) + 18'(period);
    if (item.edge_time > last_edge) begin
      gap = 17'(item.edge_time - last_edge);
    end else if (wrap_sum >= 18'(last_edge)) begin
      gap = 17'(wrap_sum - 18'(last_edge));
    end else begin
      gap = '0;
    end
    is_sync  = gap > {1'b0, sync_gap};
    gap_sat  = gap[16] ? 16'hFFFF : gap[15:0];
    read_hit = ({1'b0, item.channel_index} < latched_count) &&
               ({1'b0, item.channel_index} < 4'(NUM_CHANNELS));
  end

  // Next control state and decoded operation
  always_comb begin
    armed_next         = armed;
    last_edge_next     = last_edge;
    next_channel_next  = next_channel;
    latched_count_next = latched_count;
    op.ev    = EV_READ_MISS;
    op.chan  = '0;
    op.width = '0;
    op.stamp = item.stamp_time;
    if (item.kind == KIND_READ) begin
      op.chan = item.channel_index;
      op.ev   = read_hit ? EV_READ_HIT : EV_READ_MISS;
    end else if (!armed) begin
      armed_next     = 1'b1;
      last_edge_next = item.edge_time;
      op.ev          = EV_ARMED;
    end else begin
      last_edge_next = item.edge_time;
      op.width       = gap_sat;
      if (is_sync) begin
        latched_count_next = next_channel;
        next_channel_next  = '0;
        op.ev              = EV_SYNC;
      end else if (next_channel < 4'(NUM_CHANNELS)) begin
        next_channel_next = next_channel + 4'd1;
        op.chan           = next_channel[2:0];
        op.ev             = EV_STORED;
      end else begin
        op.ev = EV_DROPPED;
      end
    end
    op.count = latched_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed         <= 1'b0;
      last_edge     <= '0;
      next_channel  <= '0;
      latched_count <= '0;
    end else if (accept) begin
      armed         <= armed_next;
      last_edge     <= last_edge_next;
      next_channel  <= next_channel_next;
      latched_count <= latched_count_next;
    end
  end

endmodule

/* rtl/ppm_frame_decoder.sv */
// PPM frame decoder: one edge or read item per cycle while the output is not stalled.
// An accepted item loads the update stage register along with the channel
// memory read, then the result register (channel memory read-modify-write);
// the result transfers once result_stall is low.
// One item per cycle, unless the output stalls, is kept by the memory read
// and write-back, with a bypass for back-to-back updates of one channel.
// Synchronous reset clears control state and loads the register defaults;
// channel records read as reset values until first written (no clear pass).
module ppm_frame_decoder import ppmfd_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  ppmfd_item_t   item,
  output logic          result_valid,
  input  logic          result_stall,
  output ppmfd_result_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [0:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  logic [15:0]   period_reg;
  logic [15:0]   sync_reg;
  logic          advance;
  logic          accept;
  ppmfd_op_t     op;
  logic          s1_valid;
  ppmfd_op_t     s1_op;
  ppmfd_rec_t    cur_rec;
  ppmfd_rec_t    new_rec;
  logic          wr_en;
  ppmfd_result_t res_next;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_reg <= TIMER_PERIOD_RST;
      sync_reg   <= SYNC_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIMER_PERIOD: period_reg <= cfg_data;
        REG_SYNC_GAP:     sync_reg   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Handshake: update stage moves when the output register frees up
  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign accept     = item_valid && !item_stall;

  ppmfd_edge_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_edge_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .timer_period(period_reg),
    .sync_gap    (sync_reg),
    .op          (op)
  );

  ppmfd_chan_mem #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_chan_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_chan(op.chan),
    .wr_en  (wr_en),
    .wr_chan(s1_op.chan),
    .wr_rec (new_rec),
    .rd_rec (cur_rec)
  );

  // Update stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= op;
    end
  end

  // Record update and result assembly
  always_comb begin
    new_rec.width = s1_op.width;
    new_rec.min_w = (s1_op.width < cur_rec.min_w) ? s1_op.width : cur_rec.min_w;
    new_rec.max_w = (s1_op.width > cur_rec.max_w) ? s1_op.width : cur_rec.max_w;
    new_rec.stamp = s1_op.stamp;
    wr_en = s1_valid && advance && (s1_op.ev == EV_STORED);

    res_next.event_res     = s1_op.ev;
    res_next.channel       = s1_op.chan;
    res_next.pulse_width   = s1_op.width;
    res_next.min_width     = '0;
    res_next.max_width     = '0;
    res_next.update_stamp  = '0;
    res_next.channel_count = s1_op.count;
    unique case (s1_op.ev)
      EV_STORED: begin
        res_next.min_width    = new_rec.min_w;
        res_next.max_width    = new_rec.max_w;
        res_next.update_stamp = new_rec.stamp;
      end
      EV_READ_HIT: begin
        res_next.pulse_width  = cur_rec.width;
        res_next.min_width    = cur_rec.min_w;
        res_next.max_width    = cur_rec.max_w;
        res_next.update_stamp = cur_rec.stamp;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result <= res_next;
    end
  end

  // Stored widths always lie inside the channel's running extremes
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.event_res == EV_STORED) |->
      (result.min_width <= result.pulse_width) &&
      (result.pulse_width <= result.max_width))
    else $error("stored width outside min/max");

  // Latched count never exceeds the channel limit
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.channel_count <= 4'(NUM_CHANNELS)))
    else $error("channel count above limit");

  // A read hit names a channel below the latched count
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.event_res == EV_READ_HIT) |->
      ({1'b0, result.channel} < result.channel_count))
    else $error("read hit beyond latched count");

  // Input is held off only while the update stage is occupied and blocked
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid && result_stall)
    else $error("input stalled without backpressure");

endmodule
